@@ src/apf_pkg.sv @@
`default_nettype none

package apf_pkg;

    typedef enum logic [1:0] {
        OP_MAP_WR  = 2'd0,
        OP_TILE_WR = 2'd1,
        OP_LINE    = 2'd2,
        OP_PIXEL   = 2'd3
    } opcode_t;

    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAP_BASE        = 3'd0,
        CFG_MAP_COLS_LOG2   = 3'd1,
        CFG_MAP_ROWS_LOG2   = 3'd2,
        CFG_OVERFLOW_ENABLE = 3'd3,
        CFG_OVERFLOW_ENTRY  = 3'd4,
        CFG_PALETTES        = 3'd5
    } cfg_index_t;

    // Map entry layout
    localparam int unsigned ENTRY_FLIP_V_BIT = 12;
    localparam int unsigned ENTRY_FLIP_H_BIT = 13;

    localparam int unsigned CMD_QUEUE_DEPTH    = 4;
    localparam int unsigned RESULT_QUEUE_DEPTH = 4;

    typedef struct packed {
        opcode_t            opcode;
        logic [15:0]        mem_addr;
        logic [15:0]        mem_data;
        logic signed [15:0] line_x;
        logic signed [15:0] line_parallax;
        logic signed [15:0] line_y;
        logic signed [15:0] step_x;
        logic signed [15:0] step_y;
        logic               eye_right;
        logic [8:0]         lead_skip;
    } item_t;

    typedef struct packed {
        logic [1:0] pixel_value;
        logic       opaque;
    } result_t;

    typedef struct packed {
        logic [3:0]  map_base;
        logic [1:0]  map_cols_log2;
        logic [1:0]  map_rows_log2;
        logic        overflow_enable;
        logic [10:0] overflow_entry;
        logic [31:0] palettes;
    } cfg_t;

    // Command passed from the front end to the memory pipeline
    typedef struct packed {
        opcode_t     op;
        logic [15:0] addr;
        logic [15:0] data;
        logic [2:0]  bpx;
        logic [2:0]  bpy;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/apf_fifo.sv @@
`default_nettype none

module apf_fifo #(
    parameter type         item_t = logic,
    parameter int unsigned DEPTH  = 4
) (
    input  wire   clk,
    input  wire   rst_n,
    input  wire   push,
    input  item_t push_item,
    output logic  full,
    input  wire   pop,
    output item_t pop_item,
    output logic  empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;
    assign do_push  = push && (!full || do_pop);

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/apf_front.sv @@
`default_nettype none

module apf_front #(
    parameter int unsigned MAP_ENTRIES = 65536
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  apf_pkg::item_t item,
    output logic           full,
    input  apf_pkg::cfg_t  cfg,
    output logic           q_push,
    output apf_pkg::cmd_t  q_item,
    input  wire            q_full
);

    localparam int unsigned MAP_W = $clog2(MAP_ENTRIES);

    logic [31:0]        acc_x_reg;
    logic [31:0]        acc_y_reg;
    logic [31:0]        acc_x_next;
    logic [31:0]        acc_y_next;
    logic               accept;

    logic [13:0]        mx_s;
    logic [13:0]        my_s;
    logic               outside;
    logic [2:0]         mask_x;
    logic [2:0]         mask_y;
    logic [6:0]         map_idx;
    logic [18:0]        pos;
    logic [15:0]        pix_addr;

    logic [16:0]        k_par;
    logic [16:0]        k_sum;
    logic signed [17:0] k_s;
    logic signed [33:0] prod_x;
    logic signed [33:0] prod_y;

    assign accept = push && !q_full;
    assign full   = q_full;

    // Map lookup address from the current accumulators
    always_comb
    begin
        mx_s    = acc_x_reg[31:18];
        my_s    = acc_y_reg[31:18];
        outside = ((mx_s >> cfg.map_cols_log2) != '0) || ((my_s >> cfg.map_rows_log2) != '0);
        mask_x  = 3'((4'd1 << cfg.map_cols_log2) - 4'd1);
        mask_y  = 3'((4'd1 << cfg.map_rows_log2) - 4'd1);
        map_idx = {3'b000, cfg.map_base}
                + ({4'b0000, acc_y_reg[20:18] & mask_y} << cfg.map_cols_log2)
                + {4'b0000, acc_x_reg[20:18] & mask_x};
        pos     = {map_idx, acc_y_reg[17:12], acc_x_reg[17:12]};
        if (cfg.overflow_enable && outside)
        begin
            pix_addr = {5'b00000, cfg.overflow_entry};
        end
        else
        begin
            pix_addr = 16'(pos[MAP_W-1:0]);
        end
    end

    // Line seed: parallax counts only for the eye its sign selects
    always_comb
    begin
        k_par = '0;
        if (!item.line_parallax[15])
        begin
            if (item.eye_right)
            begin
                k_par = {1'b0, item.line_parallax};
            end
        end
        else if (!item.eye_right)
        begin
            k_par = 17'd0 - {1'b1, item.line_parallax};
        end
        k_sum  = k_par + {8'd0, item.lead_skip};
        k_s    = {1'b0, k_sum};
        prod_x = k_s * item.step_x;
        prod_y = k_s * item.step_y;
    end

    always_comb
    begin
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        case (item.opcode)
            apf_pkg::OP_LINE:
            begin
                acc_x_next = {{10{item.line_x[15]}}, item.line_x, 6'b000000} + prod_x[31:0];
                acc_y_next = {{10{item.line_y[15]}}, item.line_y, 6'b000000} + prod_y[31:0];
            end
            apf_pkg::OP_PIXEL:
            begin
                acc_x_next = acc_x_reg + {{16{item.step_x[15]}}, item.step_x};
                acc_y_next = acc_y_reg + {{16{item.step_y[15]}}, item.step_y};
            end
            default:
            begin
                acc_x_next = acc_x_reg;
                acc_y_next = acc_y_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (accept)
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

    // Line starts end here; writes and pixels go on to the memories
    assign q_push      = accept && (item.opcode != apf_pkg::OP_LINE);
    assign q_item.op   = item.opcode;
    assign q_item.addr = (item.opcode == apf_pkg::OP_PIXEL) ? pix_addr : item.mem_addr;
    assign q_item.data = item.mem_data;
    assign q_item.bpx  = acc_x_reg[11:9];
    assign q_item.bpy  = acc_y_reg[11:9];

endmodule

`default_nettype wire

@@ src/apf_back.sv @@
`default_nettype none

module apf_back #(
    parameter int unsigned MAP_ENTRIES = 65536,
    parameter int unsigned TILE_COUNT  = 2048
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              q_empty,
    input  apf_pkg::cmd_t    q_item,
    output logic             q_pop,
    input  wire [31:0]       palettes,
    output logic             r_push,
    output apf_pkg::result_t r_item,
    input  wire              r_ready
);

    localparam int unsigned MAP_W  = $clog2(MAP_ENTRIES);
    localparam int unsigned TILE_W = $clog2(TILE_COUNT);
    localparam int unsigned ROW_W  = TILE_W + 3;
    localparam int unsigned ROWS   = TILE_COUNT * 8;

    logic [15:0]    map_mem  [MAP_ENTRIES];
    logic [15:0]    tile_mem [ROWS];

    logic           adv;

    // Stage B: map entry read back
    logic           b_valid_reg;
    apf_pkg::cmd_t  b_cmd_reg;
    logic [15:0]    map_rd_reg;
    logic [2:0]     b_py;
    logic [2:0]     b_px;
    logic [ROW_W-1:0] row_rd_addr;

    // Stage C: tile row read back
    logic           c_valid_reg;
    logic [2:0]     c_px_reg;
    logic [1:0]     c_pal_reg;
    logic [15:0]    tile_rd_reg;
    logic [1:0]     cidx;
    logic [7:0]     pal_byte;

    // Whole pipeline moves together; it halts only on a full result queue
    assign adv   = r_ready;
    assign q_pop = adv && !q_empty;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_item.op == apf_pkg::OP_MAP_WR)
            begin
                map_mem[q_item.addr[MAP_W-1:0]] <= q_item.data;
            end
            if (q_item.op == apf_pkg::OP_PIXEL)
            begin
                map_rd_reg <= map_mem[q_item.addr[MAP_W-1:0]];
            end
        end
        if (adv)
        begin
            b_cmd_reg <= q_item;
        end
    end

    assign b_py = map_rd_reg[apf_pkg::ENTRY_FLIP_V_BIT] ? ~b_cmd_reg.bpy : b_cmd_reg.bpy;
    assign b_px = map_rd_reg[apf_pkg::ENTRY_FLIP_H_BIT] ? ~b_cmd_reg.bpx : b_cmd_reg.bpx;
    assign row_rd_addr = {map_rd_reg[TILE_W-1:0], b_py};

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            if (b_cmd_reg.op == apf_pkg::OP_TILE_WR)
            begin
                tile_mem[b_cmd_reg.addr[ROW_W-1:0]] <= b_cmd_reg.data;
            end
            if (b_cmd_reg.op == apf_pkg::OP_PIXEL)
            begin
                tile_rd_reg <= tile_mem[row_rd_addr];
            end
        end
        if (adv)
        begin
            c_px_reg  <= b_px;
            c_pal_reg <= map_rd_reg[15:14];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= !q_empty;
            c_valid_reg <= b_valid_reg && (b_cmd_reg.op == apf_pkg::OP_PIXEL);
        end
    end

    assign cidx     = 2'(tile_rd_reg >> {c_px_reg, 1'b0});
    assign pal_byte = 8'(palettes >> {c_pal_reg, 3'b000});

    assign r_push             = adv && c_valid_reg;
    assign r_item.pixel_value = (cidx != 2'd0) ? 2'(pal_byte >> {cidx, 1'b0}) : 2'd0;
    assign r_item.opaque      = (cidx != 2'd0);

endmodule

`default_nettype wire

@@ src/affine_tilemap_pixel_fetch.sv @@
// Affine tilemap pixel fetch. Items go in through a queue-style port (push/full) and
// pixel results come out through another (empty/pop). Map-write, tile-write and pixel
// items each pass through the front end into the command queue, so one item per clock
// is sustained as long as results are drained; a line start only reseeds the coordinate
// accumulators and produces no result. An accepted pixel item passes in turn through the
// command queue, the map memory read, the tile memory read and the result queue, each
// memory having a single port used once per cycle. Write config registers only while
// the block is idle. Map and tile memories come up holding garbage; load every entry a
// pixel can reach before fetching pixels.
`default_nettype none

module affine_tilemap_pixel_fetch #(
    parameter int unsigned MAP_ENTRIES = 65536,
    parameter int unsigned TILE_COUNT  = 2048
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                push,
    input  apf_pkg::item_t                     item,
    output logic                               full,
    input  wire                                pop,
    output apf_pkg::result_t                   result,
    output logic                               empty,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [apf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [31:0]                         cfg_data
);

    apf_pkg::cfg_t    cfg_reg;
    logic             q_push;
    apf_pkg::cmd_t    q_push_item;
    logic             q_full;
    logic             q_pop;
    apf_pkg::cmd_t    q_head;
    logic             q_empty;
    logic             r_push;
    apf_pkg::result_t r_item;
    logic             r_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                apf_pkg::CFG_MAP_BASE:        cfg_reg.map_base        <= cfg_data[3:0];
                apf_pkg::CFG_MAP_COLS_LOG2:   cfg_reg.map_cols_log2   <= cfg_data[1:0];
                apf_pkg::CFG_MAP_ROWS_LOG2:   cfg_reg.map_rows_log2   <= cfg_data[1:0];
                apf_pkg::CFG_OVERFLOW_ENABLE: cfg_reg.overflow_enable <= cfg_data[0];
                apf_pkg::CFG_OVERFLOW_ENTRY:  cfg_reg.overflow_entry  <= cfg_data[10:0];
                apf_pkg::CFG_PALETTES:        cfg_reg.palettes        <= cfg_data;
                default:                      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    apf_front #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .cfg    (cfg_reg),
        .q_push (q_push),
        .q_item (q_push_item),
        .q_full (q_full)
    );

    apf_fifo #(
        .item_t (apf_pkg::cmd_t),
        .DEPTH  (apf_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_head),
        .empty     (q_empty)
    );

    apf_back #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .TILE_COUNT  (TILE_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .palettes (cfg_reg.palettes),
        .r_push   (r_push),
        .r_item   (r_item),
        .r_ready  (!r_full || (pop && !empty))
    );

    apf_fifo #(
        .item_t (apf_pkg::result_t),
        .DEPTH  (apf_pkg::RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (r_push),
        .push_item (r_item),
        .full      (r_full),
        .pop       (pop),
        .pop_item  (result),
        .empty     (empty)
    );

endmodule

`default_nettype wire

@@ src/apf_checker.sv @@
`default_nettype none

module apf_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              full,
    input wire              pop,
    input wire              empty,
    input apf_pkg::result_t result,
    input wire              cfg_valid,
    input wire              cfg_ready
);

    // A transparent pixel always reads back as shade zero
    a_transparent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.opaque |-> result.pixel_value == 2'd0)
        else $error("transparent pixel with nonzero shade");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed before pop");

    // Both queues come out of reset drained
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> empty && !full)
        else $error("queues not clear after reset");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind affine_tilemap_pixel_fetch apf_checker u_apf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
